// ----- sv/assert_macros.svh -----
// assertion macros used by mc_option_payoff_accumulator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/mcopa_pkg.sv -----
// constants, types and coefficient table for the option payoff accumulator
`timescale 1ns / 1ps
package mcopa_pkg;

  localparam int COUNT_BITS = 32;
  localparam int CNT_EXT_W  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam int ACC_W      = 63;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CFG_IDX_W  = 3;

  localparam logic [2:0] REG_SPOT   = 3'd0;
  localparam logic [2:0] REG_STRIKE = 3'd1;
  localparam logic [2:0] REG_DRIFT  = 3'd2;
  localparam logic [2:0] REG_VOL    = 3'd3;
  localparam logic [2:0] REG_DISC   = 3'd4;
  localparam logic [2:0] REG_CALL   = 3'd5;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic signed [36:0] X_LIM = 37'sd536870912;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef struct packed {
    logic [31:0]        spot;
    logic [31:0]        strike;
    logic signed [31:0] drift;
    logic [31:0]        vol;
    logic [31:0]        disc;
    logic               is_call;
  } cfg_t;

  // 2^f polynomial, Q2.30, ln2^n / n!
  function automatic logic [31:0] poly_coef(input logic [2:0] n);
    logic [31:0] c;
    case (n)
      3'd0: c = 32'd1073741824;
      3'd1: c = 32'd744261118;
      3'd2: c = 32'd257941248;
      3'd3: c = 32'd59597083;
      3'd4: c = 32'd10327388;
      3'd5: c = 32'd1431680;
      3'd6: c = 32'd165394;
      3'd7: c = 32'd16378;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/mcopa_in_if.sv -----
// input channel: one normal draw per beat
`timescale 1ns / 1ps
interface mcopa_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_sample;
  logic               start_run;

  modport source (output valid, normal_sample, start_run, input ready);
  modport sink (input valid, normal_sample, start_run, output ready);
endinterface

// ----- sv/mcopa_out_if.sv -----
// output channel: path value and running statistics per beat
`timescale 1ns / 1ps
interface mcopa_out_if;
  logic                         valid;
  logic                         ready;
  logic [31:0]                  path_value;
  logic [mcopa_pkg::ACC_W-1:0]  running_sum;
  logic [mcopa_pkg::ACC_W-1:0]  running_sum_sq;
  logic [31:0]                  paths_done;

  modport source (output valid, path_value, running_sum, running_sum_sq, paths_done,
                  input ready);
  modport sink (input valid, path_value, running_sum, running_sum_sq, paths_done,
                output ready);
endinterface

// ----- sv/mc_option_payoff_accumulator.sv -----
// Monte Carlo path evaluator: one normal draw in, discounted payoff and running sums out.
// Per path, a sequencer drives a single 33x33 multiplier through the exponent, the range
// reduction, seven Horner steps of the 2^f polynomial, the spot scale, the two halves of
// the discount and the square. The input is ready only while the sequencer is idle; the
// result sits in an output register, so a new draw is taken while the previous result
// waits. Sums saturate at 2^63-1; start_run clears them when its beat is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mc_option_payoff_accumulator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mcopa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  mcopa_in_if.sink                        path_in,
  mcopa_out_if.source                     result
);
  import mcopa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MZ   = 4'd1;
  localparam logic [3:0] S_X    = 4'd2;
  localparam logic [3:0] S_MX   = 4'd3;
  localparam logic [3:0] S_T    = 4'd4;
  localparam logic [3:0] S_H    = 4'd5;
  localparam logic [3:0] S_HA   = 4'd6;
  localparam logic [3:0] S_MS   = 4'd7;
  localparam logic [3:0] S_ST   = 4'd8;
  localparam logic [3:0] S_DL   = 4'd9;
  localparam logic [3:0] S_DH   = 4'd10;
  localparam logic [3:0] S_PV   = 4'd11;
  localparam logic [3:0] S_SQ   = 4'd12;
  localparam logic [3:0] S_ACC  = 4'd13;

  cfg_t cfg;

  logic [3:0]                state;
  logic signed [15:0]        z;
  logic signed [30:0]        xc;
  logic signed [6:0]         k;
  logic [29:0]               f30;
  logic [31:0]               q;
  logic [2:0]                hn;
  logic [ACC_W-1:0]          payoff;
  logic [31:0]               lo_part;
  logic [31:0]               pv;
  logic [ACC_W-1:0]          sum_acc;
  logic [ACC_W-1:0]          sum_sq_acc;
  logic [COUNT_BITS-1:0]     path_count;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic                      in_fire;
  logic                      acc_fire;
  logic signed [36:0]        x_raw;
  logic signed [30:0]        t_val;
  logic signed [7:0]         sh;
  logic [5:0]                lsh;
  logic [63:0]               m;
  logic [ACC_W-1:0]          st;
  logic [63:0]               pv_wide;
  logic [63:0]               sum_wide;
  logic [63:0]               sq_wide;
  logic [COUNT_BITS-1:0]     cnt_next;
  logic [CNT_EXT_W-1:0]      cnt_ext;

  mcopa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcopa_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign path_in.ready = (state == S_IDLE);
  assign in_fire       = path_in.valid && path_in.ready;
  assign acc_fire      = (state == S_ACC) && !(result.valid && !result.ready);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MZ: begin
        mul_a = {{(MUL_W-16){z[15]}}, z};
        mul_b = {1'b0, cfg.vol};
      end
      S_MX: begin
        mul_a = {{(MUL_W-31){xc[30]}}, xc};
        mul_b = {2'b00, LOG2E_Q30};
      end
      S_H: begin
        mul_a = {1'b0, q};
        mul_b = {3'b000, f30};
      end
      S_MS: begin
        mul_a = {1'b0, cfg.spot};
        mul_b = {1'b0, q};
      end
      S_DL: begin
        mul_a = {1'b0, payoff[31:0]};
        mul_b = {1'b0, cfg.disc};
      end
      S_DH: begin
        mul_a = {2'b00, payoff[62:32]};
        mul_b = {1'b0, cfg.disc};
      end
      // square stays on the multiplier while the output stalls
      S_SQ, S_ACC: begin
        mul_a = {1'b0, pv};
        mul_b = {1'b0, pv};
      end
      default: ;
    endcase
  end

  // exponent, log2 split, terminal price shift, and the present value, sum and count updates
  always_comb begin
    x_raw = 37'(cfg.drift) + $signed(prod[48:12]);
    t_val = $signed(prod[60:30]);
    sh    = 8'sd30 - 8'(k);
    lsh   = 6'(-sh);
    m     = prod[63:0];
    if (sh >= 8'sd64) begin
      st = '0;
    end else if (sh >= 8'sd0) begin
      st = 63'(m >> sh[5:0]);
    end else if (m > ({1'b0, ACC_MAX} >> lsh)) begin
      st = ACC_MAX;
    end else begin
      st = 63'(m << lsh);
    end
    pv_wide  = prod[63:0] + {32'd0, lo_part};
    sum_wide = {1'b0, sum_acc} + {32'd0, pv};
    sq_wide  = {1'b0, sum_sq_acc} + {16'd0, prod[63:16]};
    cnt_next = (path_count == {COUNT_BITS{1'b1}}) ? path_count : path_count + 1'b1;
    cnt_ext  = CNT_EXT_W'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sum_acc      <= '0;
      sum_sq_acc   <= '0;
      path_count   <= '0;
      result.valid <= 1'b0;
      hn           <= '0;
    end else begin
      if (result.valid && result.ready && !acc_fire) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            z <= path_in.normal_sample;
            if (path_in.start_run) begin
              sum_acc    <= '0;
              sum_sq_acc <= '0;
              path_count <= '0;
            end
            state <= S_MZ;
          end
        end
        S_MZ: state <= S_X;
        S_X: begin
          // clamp only picks between saturated and zero price
          if (x_raw > X_LIM) begin
            xc <= 31'(X_LIM);
          end else if (x_raw < -X_LIM) begin
            xc <= 31'(-X_LIM);
          end else begin
            xc <= 31'(x_raw);
          end
          state <= S_MX;
        end
        S_MX: state <= S_T;
        S_T: begin
          k     <= t_val[30:24];
          f30   <= {t_val[23:0], 6'd0};
          q     <= poly_coef(3'd7);
          hn    <= 3'd6;
          state <= S_H;
        end
        S_H: state <= S_HA;
        S_HA: begin
          q <= poly_coef(hn) + prod[61:30];
          if (hn == 3'd0) begin
            state <= S_MS;
          end else begin
            hn    <= hn - 3'd1;
            state <= S_H;
          end
        end
        S_MS: state <= S_ST;
        S_ST: begin
          if (cfg.is_call) begin
            payoff <= (st > 63'(cfg.strike)) ? st - 63'(cfg.strike) : '0;
          end else begin
            payoff <= (63'(cfg.strike) > st) ? 63'(cfg.strike) - st : '0;
          end
          state <= S_DL;
        end
        S_DL: state <= S_DH;
        S_DH: begin
          lo_part <= prod[63:32];
          state   <= S_PV;
        end
        S_PV: begin
          pv    <= (pv_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pv_wide[31:0];
          state <= S_SQ;
        end
        S_SQ: state <= S_ACC;
        S_ACC: begin
          if (acc_fire) begin
            sum_acc    <= (sum_wide > {1'b0, ACC_MAX}) ? ACC_MAX : sum_wide[62:0];
            sum_sq_acc <= (sq_wide > {1'b0, ACC_MAX}) ? ACC_MAX : sq_wide[62:0];
            path_count <= cnt_next;
            result.valid          <= 1'b1;
            result.path_value     <= pv;
            result.running_sum    <= (sum_wide > {1'b0, ACC_MAX}) ? ACC_MAX : sum_wide[62:0];
            result.running_sum_sq <= (sq_wide > {1'b0, ACC_MAX}) ? ACC_MAX : sq_wide[62:0];
            result.paths_done     <= (cnt_ext > CNT_EXT_W'(32'hFFFF_FFFF)) ?
                                     32'hFFFF_FFFF : cnt_ext[31:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_starts, clk, rst, in_fire, state == S_MZ)
  `ASSERT_NOW(a_horner_done, clk, rst, state == S_MS, hn == 3'd0)
  `ASSERT_NEXT(a_sum_monotone, clk, rst, acc_fire, sum_acc >= $past(sum_acc))
  `ASSERT_NEXT(a_count_nonzero, clk, rst, acc_fire, path_count != '0 && result.valid)
endmodule

// ----- sv/mcopa_mul.sv -----
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module mcopa_mul (
  input  logic                                clk,
  input  logic signed [mcopa_pkg::MUL_W-1:0]  a,
  input  logic signed [mcopa_pkg::MUL_W-1:0]  b,
  output logic signed [mcopa_pkg::PROD_W-1:0] p
);
  import mcopa_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// ----- sv/mcopa_cfg.sv -----
// configuration register file
`timescale 1ns / 1ps
module mcopa_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mcopa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  output mcopa_pkg::cfg_t                 cfg
);
  import mcopa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spot    <= 32'd6553600;
      cfg.strike  <= 32'd6553600;
      cfg.drift   <= '0;
      cfg.vol     <= 32'd3355443;
      cfg.disc    <= 32'hFFFF_FFFF;
      cfg.is_call <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPOT:   cfg.spot    <= cfg_data;
        REG_STRIKE: cfg.strike  <= cfg_data;
        REG_DRIFT:  cfg.drift   <= $signed(cfg_data);
        REG_VOL:    cfg.vol     <= cfg_data;
        REG_DISC:   cfg.disc    <= cfg_data;
        REG_CALL:   cfg.is_call <= cfg_data[0];
        default: ;
      endcase
    end
  end
endmodule
